// ===== rtl/sst_pkg.sv =====
// Package for the seat session table.
// Holds the field widths, request kinds, table entry layout and engine states.
// No dependencies.
package sst_pkg;

  localparam int KIND_W  = 2;
  localparam int USER_W  = 16;
  localparam int PROC_W  = 32;
  localparam int TERM_W  = 8;
  localparam int COUNT_W = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLAIM  = 2'd0,
    KIND_EXIT   = 2'd1,
    KIND_SWITCH = 2'd2
  } kind_t;

  typedef struct packed {
    logic [USER_W-1:0] uid;
    logic [PROC_W-1:0] pid;
    logic [TERM_W-1:0] term;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [USER_W-1:0] user_id;
    logic [PROC_W-1:0] process_id;
    logic [TERM_W-1:0] terminal;
  } sst_req_t;

  typedef struct packed {
    logic [USER_W-1:0]  owner_user;
    logic [COUNT_W-1:0] session_count;
    logic [TERM_W-1:0]  current_terminal;
  } sst_res_t;

  typedef struct packed {
    logic idle;
    logic done;
  } sst_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_SHIFT,
    ST_APPEND,
    ST_OWNER,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/sst_req_if.sv =====
// Request channel of the seat session table: valid, ready and the request fields.
// Depends on sst_pkg.
interface sst_req_if;
  import sst_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [USER_W-1:0] user_id;
  logic [PROC_W-1:0] process_id;
  logic [TERM_W-1:0] terminal;

  modport source (output valid, kind, user_id, process_id, terminal, input ready);
  modport sink (input valid, kind, user_id, process_id, terminal, output ready);
endinterface

// ===== rtl/sst_res_if.sv =====
// Result channel of the seat session table: valid, ready and the result fields.
// Depends on sst_pkg.
interface sst_res_if;
  import sst_pkg::*;

  logic               valid;
  logic               ready;
  logic [USER_W-1:0]  owner_user;
  logic [COUNT_W-1:0] session_count;
  logic [TERM_W-1:0]  current_terminal;

  modport source (output valid, owner_user, session_count, current_terminal, input ready);
  modport sink (input valid, owner_user, session_count, current_terminal, output ready);
endinterface

// ===== rtl/sst_mem.sv =====
// Session table storage: one write port and one read port with registered read data.
// Depends on sst_pkg for the entry layout.
module sst_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  sst_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output sst_pkg::entry_t rdata
);
  import sst_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sst_engine.sv =====
// Sequencer of the seat session table: search, compaction, append and owner scan.
// Walks the table in sst_mem one entry per cycle. Depends on sst_pkg and sst_mem.
module sst_engine #(
  parameter int MAX_SESSIONS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  sst_pkg::sst_req_t          req,
  input  logic [sst_pkg::USER_W-1:0] root_user,
  input  logic                       take,
  output sst_pkg::sst_status_t       status,
  output sst_pkg::sst_res_t          result
);
  import sst_pkg::*;

  localparam int AW = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;
  localparam int CW = $clog2(MAX_SESSIONS + 1);

  state_t            state, state_next;
  sst_req_t          cur, cur_next;
  logic [CW-1:0]     ptr, ptr_next;
  logic [CW-1:0]     count, count_next;
  logic              pend, pend_next;
  logic [AW-1:0]     pend_addr, pend_addr_next;
  logic [TERM_W-1:0] active, active_next;
  logic [USER_W-1:0] owner, owner_next;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        rd;

  logic is_claim, full, pid_hit, term_hit, scan_end;

  sst_mem #(.DEPTH(MAX_SESSIONS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd)
  );

  assign is_claim = (cur.kind == KIND_CLAIM);
  assign full     = (count == CW'(MAX_SESSIONS));
  assign pid_hit  = pend && (rd.pid == cur.process_id);
  assign term_hit = pend && (rd.term == active);
  assign scan_end = !pend && ((state == ST_OWNER) ? (ptr == '0) : (ptr == count));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (req.kind)
            KIND_CLAIM:  state_next = ST_FIND;
            KIND_EXIT:   state_next = ST_FIND;
            KIND_SWITCH: state_next = ST_OWNER;
            default:     state_next = ST_DONE;
          endcase
        end
      end
      ST_FIND: begin
        if (pid_hit) begin
          state_next = ST_SHIFT;
        end else if (scan_end) begin
          if (is_claim) begin
            state_next = full ? ST_SHIFT : ST_APPEND;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SHIFT: begin
        if (scan_end) begin
          state_next = is_claim ? ST_APPEND : ST_OWNER;
        end
      end
      ST_APPEND: state_next = ST_OWNER;
      ST_OWNER: begin
        if (term_hit || scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_next       = cur;
    ptr_next       = ptr;
    count_next     = count;
    pend_next      = 1'b0;
    pend_addr_next = pend_addr;
    active_next    = active;
    owner_next     = owner;
    mem_we         = 1'b0;
    mem_waddr      = pend_addr - AW'(1);
    mem_wdata      = rd;
    mem_raddr      = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cur_next = req;
          ptr_next = (req.kind == KIND_SWITCH) ? count : '0;
          if (req.kind == KIND_SWITCH) begin
            active_next = req.terminal;
          end
        end
      end
      ST_FIND: begin
        if (ptr != count) begin
          mem_raddr      = ptr[AW-1:0];
          ptr_next       = ptr + CW'(1);
          pend_next      = 1'b1;
          pend_addr_next = ptr[AW-1:0];
        end
        if (pid_hit) begin
          ptr_next  = CW'(pend_addr) + CW'(1);
          pend_next = 1'b0;
        end else if (scan_end && is_claim && full) begin
          ptr_next = CW'(1);
        end
      end
      ST_SHIFT: begin
        if (ptr != count) begin
          mem_raddr      = ptr[AW-1:0];
          ptr_next       = ptr + CW'(1);
          pend_next      = 1'b1;
          pend_addr_next = ptr[AW-1:0];
        end
        if (pend) begin
          mem_we = 1'b1;
        end
        if (scan_end) begin
          count_next = count - CW'(1);
          ptr_next   = count_next;
        end
      end
      ST_APPEND: begin
        mem_we     = 1'b1;
        mem_waddr  = count[AW-1:0];
        mem_wdata  = '{uid: cur.user_id, pid: cur.process_id, term: cur.terminal};
        count_next = count + CW'(1);
        ptr_next   = count_next;
      end
      ST_OWNER: begin
        if (ptr != '0) begin
          mem_raddr = AW'(ptr - CW'(1));
          ptr_next  = ptr - CW'(1);
          pend_next = 1'b1;
        end
        if (term_hit) begin
          owner_next = rd.uid;
        end else if (scan_end) begin
          owner_next = root_user;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      active <= '0;
      owner  <= '0;
      pend   <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      active <= active_next;
      owner  <= owner_next;
      pend   <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    ptr       <= ptr_next;
    pend_addr <= pend_addr_next;
  end

  assign status.idle             = (state == ST_IDLE);
  assign status.done             = (state == ST_DONE);
  assign result.owner_user       = owner;
  assign result.session_count    = COUNT_W'(count);
  assign result.current_terminal = active;

endmodule

// ===== rtl/seat_session_table.sv =====
// Seat session table top level: root user register, request intake and result register.
// The search, compaction and owner scan each walk the table entry by entry through the single
// read port of the table memory.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset clears the count, active terminal, owner, root user, state, pending flag and
// result valid; table contents stay unknown and are never read before they are written.
module seat_session_table #(
  parameter int MAX_SESSIONS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [sst_pkg::USER_W-1:0] cfg_wr_data,
  sst_req_if.sink                    req,
  sst_res_if.source                  res
);
  import sst_pkg::*;

  logic [USER_W-1:0] root_user;
  sst_req_t          req_data;
  sst_status_t       status;
  sst_res_t          result;
  logic              start;
  logic              take;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_user <= '0;
    end else if (cfg_wr_en) begin
      root_user <= cfg_wr_data;
    end
  end

  assign req_data = '{kind: req.kind, user_id: req.user_id,
                      process_id: req.process_id, terminal: req.terminal};
  assign req.ready = status.idle;
  assign start     = req.valid && req.ready;
  assign take      = status.done && (!res.valid || res.ready);

  sst_engine #(.MAX_SESSIONS(MAX_SESSIONS)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req_data),
    .root_user (root_user),
    .take      (take),
    .status    (status),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (take) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.owner_user       <= result.owner_user;
      res.session_count    <= result.session_count;
      res.current_terminal <= result.current_terminal;
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> !status.idle)
    else $error("engine idle right after taking a request");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    status.done && !take |=> status.done)
    else $error("engine dropped a result that was not registered");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    take |=> status.idle && res.valid)
    else $error("result not registered or engine not idle after handoff");

endmodule
